// File: rtl/bpq_pkg.sv
// Shared types and codes for the bucket priority queue.
// Request and response payloads, status and kind codes, chain control bundle.
// No dependencies.
package bpq_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_LEVEL = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  localparam int unsigned FieldElemW = 32;
  localparam int unsigned FieldLevelW = 4;
  localparam int unsigned FieldOccW = 7;

  typedef struct packed {
    logic                   kind;
    logic [FieldElemW-1:0]  element;
    logic [FieldLevelW-1:0] level;
  } bpq_in_t;

  typedef struct packed {
    logic [FieldElemW-1:0]  front_element;
    logic [FieldLevelW-1:0] front_level;
    logic [FieldOccW-1:0]   occupancy;
    logic                   is_empty;
    logic [1:0]             status;
  } bpq_out_t;

  // Command broadcast to every cell of the chain for one step.
  typedef struct packed {
    logic                   enq;
    logic                   deq;
    logic [FieldLevelW-1:0] level;
    logic [FieldElemW-1:0]  element;
  } chain_ctrl_t;

endpackage

// File: rtl/bucket_priority_queue_unit.sv
// Bucket priority queue: multi-level FIFO priority queue on a sorted cell chain.
// Top level with request/response channels and the max_level register.
// Depends on bpq_pkg and bpq_chain.
//
// Usage:
//   Requests arrive on in_valid_i/in_ready_o with in_req_i (kind, element,
//   level). Kind enqueue stores element at level; kind dequeue drops the
//   front element. Each request yields one response on out_valid_o/out_ready_i
//   describing the queue after the step: front element and level (zero when
//   empty), occupancy, empty flag and a status code (ok, full, empty, level).
//   A rejected request leaves the stored contents unchanged.
//   A request is latched at acceptance and applied to the chain once the
//   response register is free, and its response is registered with that step;
//   no new request is accepted until the latched one has been applied.
//   The request stage accepts while a finished response waits; a stalled
//   receiver holds the applied step back until the response register frees.
//   max_level is written on cfg_valid_i/cfg_ready_o (always ready). The user
//   must write it only while no request is in flight; not enforced here.
//   Reset empties the queue at once (valid bits clear) and sets max_level to 15.
module bucket_priority_queue_unit import bpq_pkg::*; #(
  parameter int unsigned NUM_LEVELS = 16,
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bpq_in_t                in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output bpq_out_t               out_rsp_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [FieldLevelW-1:0] cfg_data_i
);

  localparam int unsigned StoreW = (ELEM_WIDTH < FieldElemW) ? ELEM_WIDTH : FieldElemW;
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);

  logic                   busy_q;
  bpq_in_t                req_q;
  logic [FieldLevelW-1:0] max_level_q;
  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q;
  bpq_out_t               out_q;

  logic                   commit;
  status_e                status;
  chain_ctrl_t            ctrl;
  logic                   head_valid;
  logic [FieldLevelW-1:0] head_level;
  logic [StoreW-1:0]      head_elem;

  assign in_ready_o  = !busy_q;
  assign cfg_ready_o = 1'b1;
  assign commit      = busy_q && (!out_valid_q || out_ready_i);

  always_comb begin
    status = ST_OK;
    if (req_q.kind == KIND_ENQ) begin
      if ((req_q.level > max_level_q) ||
          ({28'd0, req_q.level} >= 32'(NUM_LEVELS))) begin
        status = ST_LEVEL;
      end else if (count_q == CntW'(CAPACITY)) begin
        status = ST_FULL;
      end
    end else if (count_q == '0) begin
      status = ST_EMPTY;
    end

    ctrl.enq     = commit && (status == ST_OK) && (req_q.kind == KIND_ENQ);
    ctrl.deq     = commit && (status == ST_OK) && (req_q.kind == KIND_DEQ);
    ctrl.level   = req_q.level;
    ctrl.element = req_q.element;

    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  bpq_chain #(.DEPTH(CAPACITY), .ELEM_W(StoreW)) u_chain (
    .clk_i,
    .rst_ni,
    .ctrl_i      (ctrl),
    .head_valid_o(head_valid),
    .head_level_o(head_level),
    .head_elem_o (head_elem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      max_level_q <= 4'd15;
    end else begin
      if (cfg_valid_i) begin
        max_level_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      count_q <= count_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (commit) begin
      out_q.front_element <= head_valid ? FieldElemW'(head_elem) : '0;
      out_q.front_level   <= head_valid ? head_level : '0;
      out_q.occupancy     <= FieldOccW'(count_d);
      out_q.is_empty      <= (count_d == '0);
      out_q.status        <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: rtl/bpq_cell.sv
// One slot of the sorted element chain.
// Holds valid, level and element; takes a neighbor's entry on shifts.
// Depends on bpq_pkg.
module bpq_cell import bpq_pkg::*; #(
  parameter int unsigned ELEM_W = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  chain_ctrl_t            ctrl_i,
  input  logic                   prev_keep_i,
  input  logic                   prev_valid_i,
  input  logic [FieldLevelW-1:0] prev_level_i,
  input  logic [ELEM_W-1:0]      prev_elem_i,
  input  logic                   next_valid_i,
  input  logic [FieldLevelW-1:0] next_level_i,
  input  logic [ELEM_W-1:0]      next_elem_i,
  output logic                   keep_o,
  output logic                   valid_o,
  output logic [FieldLevelW-1:0] level_o,
  output logic [ELEM_W-1:0]      elem_o,
  output logic                   valid_d_o,
  output logic [FieldLevelW-1:0] level_d_o,
  output logic [ELEM_W-1:0]      elem_d_o
);

  logic                   valid_q, valid_d;
  logic [FieldLevelW-1:0] level_q, level_d;
  logic [ELEM_W-1:0]      elem_q, elem_d;

  // Entries at or below the new level stay ahead of it (FIFO within a level).
  assign keep_o = valid_q && (level_q <= ctrl_i.level);

  always_comb begin
    valid_d = valid_q;
    level_d = level_q;
    elem_d  = elem_q;
    if (ctrl_i.deq) begin
      valid_d = next_valid_i;
      level_d = next_level_i;
      elem_d  = next_elem_i;
    end else if (ctrl_i.enq && !keep_o) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        level_d = ctrl_i.level;
        elem_d  = ctrl_i.element[ELEM_W-1:0];
      end else begin
        valid_d = prev_valid_i;
        level_d = prev_level_i;
        elem_d  = prev_elem_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    elem_q  <= elem_d;
  end

  assign valid_o   = valid_q;
  assign level_o   = level_q;
  assign elem_o    = elem_q;
  assign valid_d_o = valid_d;
  assign level_d_o = level_d;
  assign elem_d_o  = elem_d;

endmodule

// File: rtl/bpq_chain.sv
// Row of bpq_cell slots kept sorted by level, then by age.
// Cell 0 is the front; exposes the front's next-cycle contents.
// Depends on bpq_pkg and bpq_cell.
module bpq_chain import bpq_pkg::*; #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ELEM_W = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  chain_ctrl_t            ctrl_i,
  output logic                   head_valid_o,
  output logic [FieldLevelW-1:0] head_level_o,
  output logic [ELEM_W-1:0]      head_elem_o
);

  logic                   keep  [DEPTH];
  logic                   valid [DEPTH];
  logic [FieldLevelW-1:0] level [DEPTH];
  logic [ELEM_W-1:0]      elem  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   p_keep, p_valid, n_valid;
    logic [FieldLevelW-1:0] p_level, n_level;
    logic [ELEM_W-1:0]      p_elem, n_elem;

    if (i == 0) begin : g_first
      assign p_keep  = 1'b1;
      assign p_valid = 1'b0;
      assign p_level = '0;
      assign p_elem  = '0;
    end else begin : g_mid
      assign p_keep  = keep[i-1];
      assign p_valid = valid[i-1];
      assign p_level = level[i-1];
      assign p_elem  = elem[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_level = '0;
      assign n_elem  = '0;
    end else begin : g_inner
      assign n_valid = valid[i+1];
      assign n_level = level[i+1];
      assign n_elem  = elem[i+1];
    end

    if (i == 0) begin : g_head
      bpq_cell #(.ELEM_W(ELEM_W)) u_cell (
        .clk_i, .rst_ni, .ctrl_i,
        .prev_keep_i (p_keep),  .prev_valid_i(p_valid),
        .prev_level_i(p_level), .prev_elem_i (p_elem),
        .next_valid_i(n_valid), .next_level_i(n_level), .next_elem_i(n_elem),
        .keep_o (keep[i]), .valid_o(valid[i]), .level_o(level[i]), .elem_o(elem[i]),
        .valid_d_o(head_valid_o), .level_d_o(head_level_o), .elem_d_o(head_elem_o)
      );
    end else begin : g_body
      bpq_cell #(.ELEM_W(ELEM_W)) u_cell (
        .clk_i, .rst_ni, .ctrl_i,
        .prev_keep_i (p_keep),  .prev_valid_i(p_valid),
        .prev_level_i(p_level), .prev_elem_i (p_elem),
        .next_valid_i(n_valid), .next_level_i(n_level), .next_elem_i(n_elem),
        .keep_o (keep[i]), .valid_o(valid[i]), .level_o(level[i]), .elem_o(elem[i]),
        .valid_d_o(), .level_d_o(), .elem_d_o()
      );
    end
  end

endmodule

// File: tb/bpq_checker.sv
// Response checker for the bucket priority queue unit.
// Watches request, response and max_level channels, predicts, compares.
// Depends on bpq_pkg.
`timescale 1ns / 100ps

module bpq_checker import bpq_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  bpq_in_t                in_req_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  bpq_out_t               out_rsp_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [FieldLevelW-1:0] cfg_data_i,
  output int                     mismatch_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [FieldLevelW-1:0] level;
    logic [FieldElemW-1:0]  element;
  } entry_t;

  // Stored elements in arrival order; the front is the first of the lowest level.
  entry_t                 stored_q[$];
  bpq_out_t               expected_q[$];
  logic [FieldLevelW-1:0] max_level;
  int                     errors;

  function automatic int front_index();
    int idx;
    idx = -1;
    foreach (stored_q[i]) begin
      if (idx < 0 || stored_q[i].level < stored_q[idx].level) begin
        idx = i;
      end
    end
    return idx;
  endfunction

  function automatic bpq_out_t apply_request(input bpq_in_t req);
    bpq_out_t rsp;
    entry_t   ent;
    int       idx;
    rsp = '0;
    rsp.status = ST_OK;
    if (req.kind == KIND_ENQ) begin
      if (req.level > max_level) begin
        rsp.status = ST_LEVEL;
      end else if (stored_q.size() >= CAPACITY) begin
        rsp.status = ST_FULL;
      end else begin
        ent.level = req.level;
        ent.element = req.element;
        stored_q.push_back(ent);
      end
    end else if (stored_q.size() == 0) begin
      rsp.status = ST_EMPTY;
    end else begin
      stored_q.delete(front_index());
    end
    idx = front_index();
    if (idx >= 0) begin
      rsp.front_element = stored_q[idx].element;
      rsp.front_level = stored_q[idx].level;
    end
    rsp.occupancy = FieldOccW'(stored_q.size());
    rsp.is_empty = (stored_q.size() == 0);
    return rsp;
  endfunction

  function automatic string rsp_text(input bpq_out_t rsp);
    return $sformatf("elem=%h level=%0d occ=%0d empty=%b status=%0d",
                     rsp.front_element, rsp.front_level, rsp.occupancy,
                     rsp.is_empty, rsp.status);
  endfunction

  task automatic check_response(input bpq_out_t act);
    bpq_out_t exp_rsp;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t checker: response with no request pending: %s", $realtime, rsp_text(act));
      end
      return;
    end
    exp_rsp = expected_q.pop_front();
    if (act.front_element !== exp_rsp.front_element ||
        act.front_level !== exp_rsp.front_level ||
        act.occupancy !== exp_rsp.occupancy ||
        act.is_empty !== exp_rsp.is_empty ||
        act.status !== exp_rsp.status) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t checker: mismatch", $realtime);
        $display("  expected %s", rsp_text(exp_rsp));
        $display("  actual   %s", rsp_text(act));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q.delete();
      expected_q.delete();
      max_level = '1;
      errors = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        max_level = cfg_data_i;
      end
      // compare before pushing so a stray response cannot take a fresh expectation
      if (out_valid_i && out_ready_i) begin
        check_response(out_rsp_i);
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(apply_request(in_req_i));
      end
      mismatch_count_o <= errors;
      pending_o <= expected_q.size();
    end
  end

endmodule

// File: tb/bucket_priority_queue_unit_test.sv
// Testbench top for the bucket priority queue unit: clock, reset, stimulus, verdict.
// Depends on bpq_pkg, bucket_priority_queue_unit and bpq_checker.
`timescale 1ns / 100ps

module bucket_priority_queue_unit_test;
  import bpq_pkg::*;

  localparam int unsigned CAPACITY       = 64;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          PHASES         = 8;
  localparam int          PHASE_ITEMS    = 125;
  localparam logic [FieldLevelW-1:0] PHASE_MAX [PHASES] =
    '{4'd15, 4'd0, 4'd7, 4'd15, 4'd3, 4'd1, 4'd14, 4'd15};

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready_o;
  bpq_in_t                in_req = '0;
  logic                   out_valid_o;
  logic                   out_ready = 1'b0;
  bpq_out_t               out_rsp_o;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready_o;
  logic [FieldLevelW-1:0] cfg_data = '0;

  int                     mismatch_count;
  int                     pending;
  int                     quiet_cycles = 0;
  int                     tx_idle_pct = 0;
  int                     rx_stall_pct = 0;
  logic                   hold_req = 1'b0;
  logic                   hold_seen = 1'b0;
  int                     hold_left = 0;
  logic [FieldLevelW-1:0] cur_max = 4'd15;
  logic                   filling = 1'b0;
  int                     run_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  bucket_priority_queue_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  bpq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready_o),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready),
    .out_rsp_i        (out_rsp_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Response side: random stalls, plus one long hold-off to back up the queue.
  always @(posedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Leaves valid high after acceptance; the next call or the caller lowers it.
  task automatic send_request(input bpq_in_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_req <= req;
    in_valid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  task automatic enqueue(input logic [FieldElemW-1:0] value,
                         input logic [FieldLevelW-1:0] lvl);
    bpq_in_t req;
    req.kind = KIND_ENQ;
    req.element = value;
    req.level = lvl;
    send_request(req);
  endtask

  // element and level are don't-care on dequeue, so fill them with noise
  task automatic dequeue();
    bpq_in_t req;
    req.kind = KIND_DEQ;
    req.element = $urandom();
    req.level = FieldLevelW'($urandom_range(15, 0));
    send_request(req);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_level(input logic [FieldLevelW-1:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    cur_max = value;
  endtask

  // Alternating fill and drain runs so the pool reaches both full and empty.
  task automatic random_request();
    logic [FieldElemW-1:0]  value;
    logic [FieldLevelW-1:0] lvl;
    int                     enq_pct;
    if (run_left == 0) begin
      filling = !filling;
      run_left = $urandom_range(100, 10);
    end
    run_left--;
    enq_pct = filling ? 90 : 25;
    if ($urandom_range(99) >= enq_pct) begin
      dequeue();
    end else begin
      case ($urandom_range(9))
        0: value = '0;
        1: value = '1;
        default: value = $urandom();
      endcase
      if ($urandom_range(99) < 85) begin
        lvl = FieldLevelW'($urandom_range(cur_max, 0));
      end else begin
        lvl = FieldLevelW'($urandom_range(15, 0));
      end
      enqueue(value, lvl);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, field extremes, FIFO order within a level
    dequeue();
    enqueue('0, 4'd15);
    enqueue('1, 4'd0);
    enqueue(32'hA5A5_5A5A, 4'd0);
    enqueue(32'h1234_5678, 4'd15);
    dequeue();
    dequeue();
    dequeue();
    dequeue();
    dequeue();
    enqueue(32'h0000_0011, 4'd5);
    enqueue(32'h0000_0022, 4'd12);
    enqueue(32'h0000_0033, 4'd5);

    // lowered limit: stored levels above it stay visible
    wait_idle();
    write_max_level(4'd3);
    enqueue(32'h0000_0044, 4'd4);
    enqueue(32'h0000_0055, 4'd15);
    enqueue(32'h0000_0066, 4'd3);
    repeat (4) dequeue();

    wait_idle();
    write_max_level(4'd0);
    enqueue(32'h0000_0077, 4'd1);
    enqueue(32'h8000_0001, 4'd0);
    dequeue();
    dequeue();

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_max_level(PHASE_MAX[p]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 69; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 69; end
        default: begin tx_idle_pct = 23; rx_stall_pct <= 23; end
      endcase
      if (p == 0) begin
        hold_req <= 1'b1;
      end
      repeat (PHASE_ITEMS) random_request();
    end

    wait_idle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
